// ----- design/opr_pkg.sv -----
package opr_pkg;

    localparam int COUNT_BITS = 16;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 14;
    localparam int QBITS      = GAIN_W - 2;
    localparam int MAG_W      = GAIN_W - 1 + COUNT_BITS;
    localparam int PROD_W     = GAIN_W + COUNT_BITS + 1;
    localparam int REM_W      = COUNT_BITS + 1;
    localparam int STEP_W     = $clog2(QBITS + 1);
    localparam int QUOT_W     = QBITS + 2;
    localparam int ONE_Q      = 4096;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FALL_GAIN_B     = CFG_IDX_W'(1);

    localparam logic signed [GAIN_W-1:0] GAIN_RISE       = GAIN_W'(8192);
    localparam logic signed [GAIN_W-1:0] GAIN_FALL       = GAIN_W'(-8192);
    localparam logic signed [GAIN_W-1:0] FALL_GAIN_RESET = GAIN_W'(-8192);

    localparam logic signed [QUOT_W:0] ONE_S     = (QUOT_W + 1)'(ONE_Q);
    localparam logic signed [QUOT_W:0] NEG_ONE_S = (QUOT_W + 1)'(-ONE_Q);

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [MAG_W-1:0]      mag;
        logic [COUNT_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [QUOT_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    // Adds the ramp offset (-1 on the rising ramp, +1 on the falling one) and clips to +-1.
    function automatic logic [OUT_W-1:0] clip_ramp(input logic signed [QUOT_W-1:0] q,
                                                   input logic                     rising);
        logic signed [QUOT_W:0] ext;
        logic signed [QUOT_W:0] sum;
        ext = {q[QUOT_W-1], q};
        sum = rising ? ext - ONE_S : ext + ONE_S;
        if (sum > ONE_S) begin
            return ONE_S[OUT_W-1:0];
        end else if (sum < NEG_ONE_S) begin
            return NEG_ONE_S[OUT_W-1:0];
        end
        return sum[OUT_W-1:0];
    endfunction

endpackage

// ----- design/opr_div.sv -----
module opr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  opr_pkg::t_div_req i_req,
    output opr_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [opr_pkg::STEP_W-1:0]          r_step;
    logic [opr_pkg::REM_W-1:0]           r_rem;
    logic [opr_pkg::QBITS-1:0]           r_low;
    logic [opr_pkg::QBITS-1:0]           r_q;
    logic [opr_pkg::COUNT_BITS-1:0]      r_den;
    logic                                r_neg;
    logic                                r_sat;

    logic [opr_pkg::REM_W-1:0]           w_hi;
    logic [opr_pkg::REM_W-1:0]           w_shift;
    logic [opr_pkg::REM_W-1:0]           w_den;
    logic                                w_ge;
    logic [opr_pkg::QUOT_W-1:0]          w_qmag;

    assign w_hi    = i_req.mag[opr_pkg::MAG_W-1:opr_pkg::QBITS];
    assign w_shift = {r_rem[opr_pkg::REM_W-2:0], r_low[opr_pkg::QBITS-1]};
    assign w_den   = {1'b0, r_den};
    assign w_ge    = (w_shift >= w_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                if (w_hi >= {1'b0, i_req.den}) begin
                    r_step <= '0;
                end else begin
                    r_step <= opr_pkg::STEP_W'(opr_pkg::QBITS);
                end
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - opr_pkg::STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.neg;
            r_den <= i_req.den;
            r_rem <= w_hi;
            r_low <= i_req.mag[opr_pkg::QBITS-1:0];
            r_q   <= '0;
            r_sat <= (w_hi >= {1'b0, i_req.den});
        end else if (r_busy && (r_step != '0)) begin
            r_rem <= w_ge ? w_shift - w_den : w_shift;
            r_low <= {r_low[opr_pkg::QBITS-2:0], 1'b0};
            r_q   <= {r_q[opr_pkg::QBITS-2:0], w_ge};
        end
    end

    assign w_qmag     = r_sat ? opr_pkg::QUOT_W'(1 << opr_pkg::QBITS) : {2'b00, r_q};
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed(w_qmag) : $signed(w_qmag);

endmodule

// ----- design/oscillator_phase_ramp_shaper.sv -----
// Each input beat runs through S_MUL, S_MAG and S_DIV (the shared 14-step serial divider)
// and S_DONE: one division per beat in the high phase, two in the low phase. A division
// whose quotient is certain to clip skips the shift steps; a zero captured length goes
// straight to S_DONE. A new beat is taken only after the last one has left S_DONE; a
// stalled output beat holds the input side off until it is taken.
// Reset (synchronous, active low) restores register defaults, the high phase and zero counts.
module oscillator_phase_ramp_shaper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,   // activity_a, activity_b
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // ramp_a, ramp_b, zero fill
    output logic                            o_m_tuser,   // phase_high
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [opr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_MAG, S_DIV, S_DONE} t_state;

    t_state                                 r_state;
    logic signed [opr_pkg::GAIN_W-1:0]      r_threshold;
    logic signed [opr_pkg::GAIN_W-1:0]      r_fall_gain;
    logic                                   r_last_high;
    logic [opr_pkg::COUNT_BITS-1:0]         r_hcnt;
    logic [opr_pkg::COUNT_BITS-1:0]         r_lcnt;
    logic [opr_pkg::COUNT_BITS-1:0]         r_hlen;
    logic [opr_pkg::COUNT_BITS-1:0]         r_llen;
    logic                                   r_high;
    logic                                   r_second;
    logic [opr_pkg::COUNT_BITS-1:0]         r_cnt;
    logic [opr_pkg::COUNT_BITS-1:0]         r_len;
    logic signed [opr_pkg::GAIN_W-1:0]      r_gain;
    logic signed [opr_pkg::PROD_W-1:0]      r_prod;
    logic [opr_pkg::OUT_W-1:0]              r_pend_a;
    logic [opr_pkg::OUT_W-1:0]              r_pend_b;
    logic                                   r_out_valid;
    logic [opr_pkg::OUT_W-1:0]              r_ramp_a;
    logic [opr_pkg::OUT_W-1:0]              r_ramp_b;
    logic                                   r_phase;

    logic signed [15:0]                     w_a;
    logic signed [15:0]                     w_b;
    logic                                   n_high;
    logic [opr_pkg::COUNT_BITS-1:0]         n_cnt;
    logic [opr_pkg::COUNT_BITS-1:0]         n_len;
    logic                                   w_accept;
    logic signed [opr_pkg::PROD_W-1:0]      w_abs;
    logic [opr_pkg::OUT_W-1:0]              w_ramp;
    opr_pkg::t_div_req                      w_req;
    opr_pkg::t_div_rsp                      w_rsp;

    assign w_a      = i_s_tdata[15:0];
    assign w_b      = i_s_tdata[31:16];
    assign n_high   = !w_b[15] && (w_a <= r_threshold);
    assign n_cnt    = n_high ? opr_pkg::sat_inc(r_hcnt) : opr_pkg::sat_inc(r_lcnt);
    assign n_len    = n_high ? r_hlen : r_llen;
    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_abs      = r_prod[opr_pkg::PROD_W-1] ? -r_prod : r_prod;
    assign w_req.start = (r_state == S_MAG);
    assign w_req.neg   = r_prod[opr_pkg::PROD_W-1];
    assign w_req.mag   = w_abs[opr_pkg::MAG_W-1:0];
    assign w_req.den   = r_len;
    assign w_ramp      = opr_pkg::clip_ramp(w_rsp.quot, r_high);

    opr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_fall_gain <= opr_pkg::FALL_GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                opr_pkg::REG_PHASE_THRESHOLD: r_threshold <= i_cfg_data;
                opr_pkg::REG_FALL_GAIN_B:     r_fall_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_high <= 1'b1;
            r_hcnt      <= '0;
            r_lcnt      <= '0;
            r_hlen      <= '0;
            r_llen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last_high <= n_high;
                        r_high      <= n_high;
                        r_cnt       <= n_cnt;
                        r_len       <= n_len;
                        r_second    <= 1'b0;
                        r_gain      <= n_high ? opr_pkg::GAIN_RISE : opr_pkg::GAIN_FALL;
                        if (n_high) begin
                            r_hcnt <= n_cnt;
                            r_lcnt <= '0;
                            if (!r_last_high) begin
                                r_llen <= r_lcnt;
                            end
                        end else begin
                            r_lcnt <= n_cnt;
                            r_hcnt <= '0;
                            if (r_last_high) begin
                                r_hlen <= r_hcnt;
                            end
                        end
                        if (n_len == '0) begin
                            r_pend_a <= '0;
                            r_pend_b <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= opr_pkg::PROD_W'(r_gain)
                               * opr_pkg::PROD_W'($signed({1'b0, r_cnt}));
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        if (r_second) begin
                            r_pend_b <= w_ramp;
                            r_state  <= S_DONE;
                        end else if (r_high) begin
                            r_pend_a <= w_ramp;
                            r_pend_b <= w_ramp;
                            r_state  <= S_DONE;
                        end else begin
                            r_pend_a <= w_ramp;
                            r_second <= 1'b1;
                            r_gain   <= r_fall_gain;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_ramp_a    <= r_pend_a;
                        r_ramp_b    <= r_pend_b;
                        r_phase     <= r_high;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0000, r_ramp_b, r_ramp_a};
    assign o_m_tuser   = r_phase;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- design/opr_checker.sv -----
module opr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    // Each input beat starts a multi-cycle computation.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted on consecutive cycles");

    a_ramp_a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[13:0]) <= 14'sd4096 &&
                        $signed(o_m_tdata[13:0]) >= -14'sd4096))
        else $error("ramp_a out of range");

    a_ramp_b_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[27:14]) <= 14'sd4096 &&
                        $signed(o_m_tdata[27:14]) >= -14'sd4096))
        else $error("ramp_b out of range");

    // In the high phase both outputs share the same rising ramp.
    a_high_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[13:0] == o_m_tdata[27:14]))
        else $error("ramps differ in high phase");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind oscillator_phase_ramp_shaper opr_checker u_opr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
